// ===== rtl/core/hsmt_pkg.sv =====
// ----------------------------------------------------------------------------
// hsmt_pkg
// types, constants and codes shared by the hashed share mode table
// ----------------------------------------------------------------------------
`default_nettype none

package hsmt_pkg;

    localparam int BUCKETS          = 256;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int SUBENTRIES       = 8;
    localparam int Q_DEPTH          = 2;

    localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NSUB     = SUBENTRIES - 1;
    localparam int SLOT_IW  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int SUB_IW   = (NSUB > 1) ? $clog2(NSUB) : 1;
    localparam int QPTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [63:0] HASH_K1 = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] HASH_K2 = 64'hFF51AFD7ED558CCD;
    localparam int          HASH_SHIFT = 33;

    localparam logic [31:0] ACC_READ   = 32'h0000_0021;
    localparam logic [31:0] ACC_WRITE  = 32'h0000_0006;
    localparam logic [31:0] ACC_DELETE = 32'h0001_0000;
    localparam logic [31:0] ACC_ALL    = ACC_READ | ACC_WRITE | ACC_DELETE;
    localparam logic [2:0]  SH_READ    = 3'd1;
    localparam logic [2:0]  SH_WRITE   = 3'd2;
    localparam logic [2:0]  SH_DELETE  = 3'd4;
    localparam logic [2:0]  SH_ALL     = 3'd7;

    localparam logic [1:0] MODE_OPEN   = 2'd0;
    localparam logic [1:0] MODE_CLOSE  = 2'd1;
    localparam logic [1:0] MODE_CHECK  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BUCKET_FULL = 3'd1;
    localparam logic [2:0] ST_SUBS_FULL   = 3'd2;
    localparam logic [2:0] ST_VIOLATION   = 3'd3;
    localparam logic [2:0] ST_ABSENT      = 3'd4;

    localparam logic [22:0] CLIENT_RESET = 23'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] device;
        logic [63:0] inode;
        logic [31:0] access_req;
        logic [2:0]  share_mode;
        logic [15:0] remaining_opens;
        logic [31:0] remaining_access;
        logic [2:0]  remaining_share;
    } req_t;

    typedef struct packed {
        req_t             req;
        logic [BKT_W-1:0] bucket;
    } work_t;

    typedef struct packed {
        logic [63:0] device;
        logic [63:0] inode;
    } slot_t;

    typedef struct packed {
        logic [22:0] owner;
        logic [15:0] open_count;
        logic [31:0] access;
        logic [2:0]  share;
    } sub_t;

    typedef slot_t [SLOTS_PER_BUCKET-1:0]          slot_row_t;
    typedef sub_t  [SLOTS_PER_BUCKET-1:0][NSUB-1:0] sub_row_t;

endpackage

`default_nettype wire

// ===== rtl/core/hsmt_intf.sv =====
// ----------------------------------------------------------------------------
// hsmt_intf
// valid/ready channels of the hashed share mode table
// ----------------------------------------------------------------------------
`default_nettype none

interface hsmt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] device;
    logic [63:0] inode;
    logic [31:0] access_req;
    logic [2:0]  share_mode;
    logic [15:0] remaining_opens;
    logic [31:0] remaining_access;
    logic [2:0]  remaining_share;

    modport source (output valid, mode, device, inode, access_req, share_mode,
                    remaining_opens, remaining_access, remaining_share, input ready);
    modport sink   (input valid, mode, device, inode, access_req, share_mode,
                    remaining_opens, remaining_access, remaining_share, output ready);
endinterface

interface hsmt_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;

    modport source (output valid, status, input ready);
    modport sink   (input valid, status, output ready);
endinterface

interface hsmt_cfg_if;
    logic        valid;
    logic        ready;
    logic [22:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hsmt_front.sv =====
// ----------------------------------------------------------------------------
// hsmt_front
// accepts request words and hashes the key to a bucket with one shared
// 32x32 multiplier, then pushes the word to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module hsmt_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    hsmt_req_if.sink            req,
    output hsmt_pkg::work_t     push_data,
    output logic                push_valid,
    input  wire logic           push_ready
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_MIX  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t                   state_reg, state_next;
    logic [1:0]                step_reg, step_next;
    logic                      pass_reg, pass_next;
    hsmt_pkg::req_t            item_reg, item_next;
    logic [63:0]               a_reg, a_next;
    logic [63:0]               acc_reg, acc_next;
    logic [hsmt_pkg::BKT_W-1:0] bucket_reg, bucket_next;

    logic [63:0] k_sel;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] h_pre, h_mix;

    assign k_sel = pass_reg ? hsmt_pkg::HASH_K2 : hsmt_pkg::HASH_K1;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                mul_a = a_reg[31:0];
                mul_b = k_sel[31:0];
            end
            2'd1:
            begin
                mul_a = a_reg[31:0];
                mul_b = k_sel[63:32];
            end
            default:
            begin
                mul_a = a_reg[63:32];
                mul_b = k_sel[31:0];
            end
        endcase
    end

    assign prod  = 64'(mul_a) * 64'(mul_b);
    assign h_pre = pass_reg ? acc_reg : acc_reg + item_reg.inode;
    assign h_mix = h_pre ^ (h_pre >> hsmt_pkg::HASH_SHIFT);

    assign req.ready  = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_data  = '{req: item_reg, bucket: bucket_reg};

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        pass_next   = pass_reg;
        item_next   = item_reg;
        a_next      = a_reg;
        acc_next    = acc_reg;
        bucket_next = bucket_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (req.valid)
                begin
                    item_next.mode             = req.mode;
                    item_next.device           = req.device;
                    item_next.inode            = req.inode;
                    item_next.access_req       = req.access_req;
                    item_next.share_mode       = req.share_mode;
                    item_next.remaining_opens  = req.remaining_opens;
                    item_next.remaining_access = req.remaining_access;
                    item_next.remaining_share  = req.remaining_share;
                    a_next     = req.device;
                    acc_next   = '0;
                    step_next  = 2'd0;
                    pass_next  = 1'b0;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                if (step_reg == 2'd0)
                begin
                    acc_next = acc_reg + prod;
                end
                else
                begin
                    acc_next = acc_reg + {prod[31:0], 32'd0};
                end
                if (step_reg == 2'd2)
                begin
                    state_next = F_MIX;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end
            F_MIX:
            begin
                if (!pass_reg)
                begin
                    a_next     = h_mix;
                    acc_next   = '0;
                    step_next  = 2'd0;
                    pass_next  = 1'b1;
                    state_next = F_MUL;
                end
                else
                begin
                    bucket_next = h_mix[hsmt_pkg::BKT_W-1:0];
                    state_next  = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= 2'd0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        a_reg      <= a_next;
        acc_reg    <= acc_next;
        bucket_reg <= bucket_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/hsmt_queue.sv =====
// ----------------------------------------------------------------------------
// hsmt_queue
// short fifo of hashed request words between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module hsmt_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire hsmt_pkg::work_t  push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output hsmt_pkg::work_t       pop_data
);

    hsmt_pkg::work_t                entry_reg [hsmt_pkg::Q_DEPTH];
    logic [hsmt_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [hsmt_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [hsmt_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           do_push, do_pop;

    assign push_ready = (count_reg != hsmt_pkg::QCNT_W'(hsmt_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == hsmt_pkg::QPTR_W'(hsmt_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == hsmt_pkg::QPTR_W'(hsmt_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hsmt_back.sv =====
// ----------------------------------------------------------------------------
// hsmt_back
// reads a bucket row, carries out open, close or check, writes the row back
// on a good open or close and holds the status word for the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module hsmt_back
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [22:0]      client_id,
    input  wire logic             pop_valid,
    output logic                  pop_ready,
    input  wire hsmt_pkg::work_t  pop_data,
    hsmt_rsp_if.source            rsp
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_EVAL = 2'b10
    } bstate_t;

    bstate_t                     state_reg, state_next;
    hsmt_pkg::work_t             work_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [2:0]                  status_reg, status_next;
    logic [hsmt_pkg::BUCKETS-1:0] row_valid_reg;
    logic                        rd_valid_reg;

    hsmt_pkg::slot_row_t slot_mem [hsmt_pkg::BUCKETS];
    hsmt_pkg::sub_row_t  sub_mem  [hsmt_pkg::BUCKETS];
    hsmt_pkg::slot_row_t slot_rd_reg;
    hsmt_pkg::sub_row_t  sub_rd_reg;

    hsmt_pkg::slot_row_t row_slots, new_slots;
    hsmt_pkg::sub_row_t  row_subs, new_subs;
    hsmt_pkg::sub_t [hsmt_pkg::NSUB-1:0] sel_subs;
    hsmt_pkg::req_t      w;

    logic                         pop;
    logic                         wr_en;
    logic                         hit, emp, own, fre, any_left;
    logic [hsmt_pkg::SLOT_IW-1:0] hit_idx, emp_idx, sel_idx;
    logic [hsmt_pkg::SUB_IW-1:0]  own_idx, fre_idx;
    logic [31:0]                  agg_acc;
    logic [2:0]                   agg_sh;
    logic                         viol_a, viol_b;
    logic [2:0]                   eval_status;
    logic                         cls;

    assign pop        = (state_reg == B_IDLE) && pop_valid && !out_valid_reg;
    assign pop_ready  = pop;
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = status_reg;
    assign w          = work_reg.req;
    assign cls        = (w.access_req & hsmt_pkg::ACC_ALL) != '0;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg    <= pop_data;
            slot_rd_reg <= slot_mem[pop_data.bucket];
            sub_rd_reg  <= sub_mem[pop_data.bucket];
        end
        if (wr_en)
        begin
            slot_mem[work_reg.bucket] <= new_slots;
            sub_mem[work_reg.bucket]  <= new_subs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                rd_valid_reg <= row_valid_reg[pop_data.bucket];
            end
            if (wr_en)
            begin
                row_valid_reg[work_reg.bucket] <= 1'b1;
            end
        end
    end

    // key and subentry search
    always_comb
    begin
        row_slots = rd_valid_reg ? slot_rd_reg : '0;
        row_subs  = rd_valid_reg ? sub_rd_reg : '0;
        hit = 1'b0;
        hit_idx = '0;
        emp = 1'b0;
        emp_idx = '0;
        for (int s = 0; s < hsmt_pkg::SLOTS_PER_BUCKET; s++)
        begin
            if (!hit && row_slots[s].device == w.device && row_slots[s].inode == w.inode)
            begin
                hit = 1'b1;
                hit_idx = hsmt_pkg::SLOT_IW'(s);
            end
            if (!emp && row_slots[s].device == '0)
            begin
                emp = 1'b1;
                emp_idx = hsmt_pkg::SLOT_IW'(s);
            end
        end
        sel_idx  = hit ? hit_idx : emp_idx;
        sel_subs = row_subs[sel_idx];
        own = 1'b0;
        own_idx = '0;
        fre = 1'b0;
        fre_idx = '0;
        agg_acc = '0;
        agg_sh  = hsmt_pkg::SH_ALL;
        for (int i = 0; i < hsmt_pkg::NSUB; i++)
        begin
            if (!own && sel_subs[i].owner == client_id)
            begin
                own = 1'b1;
                own_idx = hsmt_pkg::SUB_IW'(i);
            end
            if (!fre && sel_subs[i].owner == '0)
            begin
                fre = 1'b1;
                fre_idx = hsmt_pkg::SUB_IW'(i);
            end
            if (sel_subs[i].owner != '0)
            begin
                if ((sel_subs[i].access & hsmt_pkg::ACC_ALL) != '0)
                begin
                    agg_sh = agg_sh & sel_subs[i].share;
                end
                agg_acc = agg_acc | sel_subs[i].access;
            end
        end
    end

    // open, close, check
    always_comb
    begin
        new_slots   = row_slots;
        new_subs    = row_subs;
        wr_en       = 1'b0;
        eval_status = hsmt_pkg::ST_OK;
        any_left    = 1'b0;
        viol_a = (((w.access_req & hsmt_pkg::ACC_READ) != '0) &&
                  ((agg_sh & hsmt_pkg::SH_READ) == '0)) ||
                 (((w.access_req & hsmt_pkg::ACC_WRITE) != '0) &&
                  ((agg_sh & hsmt_pkg::SH_WRITE) == '0)) ||
                 (((w.access_req & hsmt_pkg::ACC_DELETE) != '0) &&
                  ((agg_sh & hsmt_pkg::SH_DELETE) == '0));
        viol_b = (((agg_acc & hsmt_pkg::ACC_READ) != '0) &&
                  ((w.share_mode & hsmt_pkg::SH_READ) == '0)) ||
                 (((agg_acc & hsmt_pkg::ACC_WRITE) != '0) &&
                  ((w.share_mode & hsmt_pkg::SH_WRITE) == '0)) ||
                 (((agg_acc & hsmt_pkg::ACC_DELETE) != '0) &&
                  ((w.share_mode & hsmt_pkg::SH_DELETE) == '0));
        case (w.mode)
            hsmt_pkg::MODE_OPEN:
            begin
                if (w.device == '0 || client_id == '0)
                begin
                    eval_status = hsmt_pkg::ST_ABSENT;
                end
                else if (!hit && !emp)
                begin
                    eval_status = hsmt_pkg::ST_BUCKET_FULL;
                end
                else if (own)
                begin
                    wr_en = 1'b1;
                    if (new_subs[sel_idx][own_idx].open_count != 16'hFFFF)
                    begin
                        new_subs[sel_idx][own_idx].open_count =
                            new_subs[sel_idx][own_idx].open_count + 16'd1;
                    end
                    new_subs[sel_idx][own_idx].access =
                        new_subs[sel_idx][own_idx].access | w.access_req;
                    if (cls)
                    begin
                        new_subs[sel_idx][own_idx].share =
                            new_subs[sel_idx][own_idx].share & w.share_mode;
                    end
                end
                else if (!fre)
                begin
                    eval_status = hsmt_pkg::ST_SUBS_FULL;
                end
                else
                begin
                    wr_en = 1'b1;
                    new_slots[sel_idx].device = w.device;
                    new_slots[sel_idx].inode  = w.inode;
                    new_subs[sel_idx][fre_idx].owner      = client_id;
                    new_subs[sel_idx][fre_idx].open_count = 16'd1;
                    new_subs[sel_idx][fre_idx].access     = w.access_req;
                    new_subs[sel_idx][fre_idx].share      = cls ? w.share_mode :
                                                            hsmt_pkg::SH_ALL;
                end
            end
            hsmt_pkg::MODE_CLOSE:
            begin
                if (w.device == '0 || client_id == '0 || !hit || !own)
                begin
                    eval_status = hsmt_pkg::ST_ABSENT;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (w.remaining_opens == '0)
                    begin
                        new_subs[sel_idx][own_idx] = '0;
                        for (int i = 0; i < hsmt_pkg::NSUB; i++)
                        begin
                            if (new_subs[sel_idx][i].owner != '0)
                            begin
                                any_left = 1'b1;
                            end
                        end
                        if (!any_left)
                        begin
                            new_slots[sel_idx] = '0;
                        end
                    end
                    else
                    begin
                        new_subs[sel_idx][own_idx].open_count = w.remaining_opens;
                        new_subs[sel_idx][own_idx].access     = w.remaining_access;
                        new_subs[sel_idx][own_idx].share      = w.remaining_share;
                    end
                end
            end
            hsmt_pkg::MODE_CHECK:
            begin
                if (w.device != '0 && hit)
                begin
                    if (viol_a || (cls && viol_b))
                    begin
                        eval_status = hsmt_pkg::ST_VIOLATION;
                    end
                end
            end
            default:
            begin
                eval_status = hsmt_pkg::ST_OK;
            end
        endcase
        if (state_reg != B_EVAL)
        begin
            wr_en = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    state_next = B_EVAL;
                end
            end
            B_EVAL:
            begin
                out_valid_next = 1'b1;
                status_next    = eval_status;
                state_next     = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    a_eval_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_EVAL) |-> $past(pop))
        else $error("evaluation without a popped word");

    a_out_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_EVAL))
        else $error("status word raised without evaluation");

    a_no_pop_with_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !out_valid_reg && (state_reg == B_IDLE))
        else $error("pop while a status word is pending");

    a_write_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> out_valid_reg)
        else $error("row write without a status word");

endmodule

`default_nettype wire

// ===== rtl/core/hashed_share_mode_table_top.sv =====
// ----------------------------------------------------------------------------
// hashed_share_mode_table_top
// set-associative table of file keys with per-client share-mode bookkeeping
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | mode, device, inode, access_req, share_mode, remaining_*
//  rsp     | out | status
//  cfg     | in  | data (client_id)
//
//  front: hashes one word at a time on the shared 32x32 multiplier
//  (three partial products for each of the two hash multiplies)
//  back: one word at a time (registered row read, update and write back,
//  then the status word must leave before the next pop)
//  a two-word queue lets the front hash while the back waits on rsp.ready
//  reset clears per-row valid bits at once; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_share_mode_table_top
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hsmt_req_if.sink    req,
    hsmt_rsp_if.source  rsp,
    hsmt_cfg_if.sink    cfg
);

    logic [22:0]     client_id_reg;
    hsmt_pkg::work_t push_data, pop_data;
    logic            push_valid, push_ready, pop_valid, pop_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_id_reg <= hsmt_pkg::CLIENT_RESET;
        end
        else if (cfg.valid)
        begin
            client_id_reg <= cfg.data;
        end
    end

    hsmt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    hsmt_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    hsmt_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .client_id  (client_id_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire
